>>> sv/bst_pkg.sv
// shared types, constants and kind codes for the byte stream tokenizer
package bst_pkg;

   localparam int COUNTER_BITS = 16;
   localparam int FIELD_W      = 16;
   localparam int MAX_RESULTS  = 3;

   typedef logic [COUNTER_BITS-1:0] cnt_type;

   typedef enum logic [2:0] {
      KIND_IDENT  = 3'd0,
      KIND_NUMBER = 3'd1,
      KIND_STRING = 3'd2,
      KIND_OPER   = 3'd3,
      KIND_SYMBOL = 3'd4,
      KIND_ERROR  = 3'd5,
      KIND_END    = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_NUMBER = 2'd2,
      MODE_STRING = 2'd3
   } mode_type;

   typedef struct packed {
      kind_type kind;
      cnt_type  offset;
      cnt_type  length;
      cnt_type  line;
      cnt_type  column;
   } rec_type;

   // all descriptors caused by one source byte
   typedef struct packed {
      logic [1:0]                 count;
      rec_type [MAX_RESULTS-1:0] recs;
   } group_type;

endpackage

>>> sv/bst_scan.sv
// scanner: mode and position state, and the descriptors produced by one byte
module bst_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          in_byte,
   input  logic                end_of_source,
   output bst_pkg::group_type group
);

   localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CH_PLUS       = 8'h2b;
   localparam logic [7:0] CH_MINUS      = 8'h2d;
   localparam logic [7:0] CH_STAR       = 8'h2a;
   localparam logic [7:0] CH_SLASH      = 8'h2f;
   localparam logic [7:0] CH_LBRACE     = 8'h7b;
   localparam logic [7:0] CH_RBRACE     = 8'h7d;
   localparam logic [7:0] CH_SEMI       = 8'h3b;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_LF         = 8'h0a;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_CR         = 8'h0d;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7a;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5a;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;

   localparam bst_pkg::cnt_type CNT_ZERO = '0;
   localparam bst_pkg::cnt_type CNT_ONE  = bst_pkg::cnt_type'(1);

   function automatic bst_pkg::cnt_type sat_inc(input bst_pkg::cnt_type v);
      return (v == '1) ? v : v + CNT_ONE;
   endfunction

   function automatic bst_pkg::rec_type make_rec(
      input bst_pkg::kind_type kind,
      input bst_pkg::cnt_type  offset,
      input bst_pkg::cnt_type  length,
      input bst_pkg::cnt_type  line,
      input bst_pkg::cnt_type  column
   );
      bst_pkg::rec_type r;
      r.kind   = kind;
      r.offset = offset;
      r.length = length;
      r.line   = line;
      r.column = column;
      return r;
   endfunction

   bst_pkg::mode_type mode_ff, mode_in;
   bst_pkg::cnt_type  offset_ff, offset_in;
   bst_pkg::cnt_type  line_ff, line_in;
   bst_pkg::cnt_type  column_ff, column_in;
   bst_pkg::cnt_type  open_offset_ff, open_offset_in;
   bst_pkg::cnt_type  open_line_ff, open_line_in;
   bst_pkg::cnt_type  open_column_ff, open_column_in;

   bst_pkg::cnt_type  offset_next, line_next, column_next;
   bst_pkg::kind_type close_kind, single_kind;
   bst_pkg::rec_type [bst_pkg::MAX_RESULTS-1:0] recs;
   logic [1:0]        n;
   logic              newline;
   logic              is_letter, is_digit, is_space;

   assign is_letter = (in_byte inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z],
                                        CH_UNDERSCORE});
   assign is_digit  = (in_byte inside {[CH_ZERO:CH_NINE]});
   assign is_space  = (in_byte inside {CH_SPACE, [CH_TAB:CH_CR]});

   always_comb begin
      if (in_byte inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) begin
         single_kind = bst_pkg::KIND_OPER;
      end else if (in_byte inside {CH_LBRACE, CH_RBRACE, CH_SEMI}) begin
         single_kind = bst_pkg::KIND_SYMBOL;
      end else begin
         single_kind = bst_pkg::KIND_ERROR;
      end
   end

   always_comb begin
      newline        = 1'b0;
      n              = '0;
      recs           = '0;
      close_kind     = bst_pkg::KIND_STRING;
      mode_in        = mode_ff;
      open_offset_in = open_offset_ff;
      open_line_in   = open_line_ff;
      open_column_in = open_column_ff;

      if (mode_ff == bst_pkg::MODE_STRING) begin
         if (in_byte == CH_QUOTE) begin
            recs[n] = make_rec(bst_pkg::KIND_STRING, open_offset_ff,
                               sat_inc(bst_pkg::cnt_type'(offset_ff - open_offset_ff)),
                               open_line_ff, open_column_ff);
            n       = n + 2'd1;
            mode_in = bst_pkg::MODE_IDLE;
         end
      end else begin
         // a byte that cannot extend the open token closes it and is then scanned afresh
         if (mode_ff == bst_pkg::MODE_IDENT && !(is_letter || is_digit)) begin
            recs[n] = make_rec(bst_pkg::KIND_IDENT, open_offset_ff,
                               bst_pkg::cnt_type'(offset_ff - open_offset_ff),
                               open_line_ff, open_column_ff);
            n       = n + 2'd1;
            mode_in = bst_pkg::MODE_IDLE;
         end else if (mode_ff == bst_pkg::MODE_NUMBER && !is_digit) begin
            recs[n] = make_rec(bst_pkg::KIND_NUMBER, open_offset_ff,
                               bst_pkg::cnt_type'(offset_ff - open_offset_ff),
                               open_line_ff, open_column_ff);
            n       = n + 2'd1;
            mode_in = bst_pkg::MODE_IDLE;
         end
         if (mode_in == bst_pkg::MODE_IDLE) begin
            if (is_space) begin
               newline = (in_byte == CH_LF);
            end else if (is_letter || is_digit || in_byte == CH_QUOTE) begin
               if (is_letter) begin
                  mode_in = bst_pkg::MODE_IDENT;
               end else if (is_digit) begin
                  mode_in = bst_pkg::MODE_NUMBER;
               end else begin
                  mode_in = bst_pkg::MODE_STRING;
               end
               open_offset_in = offset_ff;
               open_line_in   = line_ff;
               open_column_in = column_ff;
            end else begin
               recs[n] = make_rec(single_kind, offset_ff, CNT_ONE, line_ff, column_ff);
               n       = n + 2'd1;
            end
         end
      end

      // end of source closes an open token, flagged byte included
      if (end_of_source && mode_in != bst_pkg::MODE_IDLE) begin
         case (mode_in)
            bst_pkg::MODE_IDENT:  close_kind = bst_pkg::KIND_IDENT;
            bst_pkg::MODE_NUMBER: close_kind = bst_pkg::KIND_NUMBER;
            default:              close_kind = bst_pkg::KIND_STRING;
         endcase
         recs[n] = make_rec(close_kind, open_offset_in,
                            sat_inc(bst_pkg::cnt_type'(offset_ff - open_offset_in)),
                            open_line_in, open_column_in);
         n       = n + 2'd1;
         mode_in = bst_pkg::MODE_IDLE;
      end

      offset_next = sat_inc(offset_ff);
      if (newline) begin
         line_next   = sat_inc(line_ff);
         column_next = CNT_ONE;
      end else begin
         line_next   = line_ff;
         column_next = sat_inc(column_ff);
      end

      offset_in = offset_next;
      line_in   = line_next;
      column_in = column_next;

      if (end_of_source) begin
         recs[n] = make_rec(bst_pkg::KIND_END, offset_next, CNT_ZERO, line_next, column_next);
         n       = n + 2'd1;
         // next byte starts a new source
         mode_in        = bst_pkg::MODE_IDLE;
         offset_in      = CNT_ZERO;
         line_in        = CNT_ONE;
         column_in      = CNT_ONE;
         open_offset_in = CNT_ZERO;
         open_line_in   = CNT_ONE;
         open_column_in = CNT_ONE;
      end

      group.count = n;
      group.recs  = recs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= bst_pkg::MODE_IDLE;
         offset_ff      <= CNT_ZERO;
         line_ff        <= CNT_ONE;
         column_ff      <= CNT_ONE;
         open_offset_ff <= CNT_ZERO;
         open_line_ff   <= CNT_ONE;
         open_column_ff <= CNT_ONE;
      end else if (advance) begin
         mode_ff        <= mode_in;
         offset_ff      <= offset_in;
         line_ff        <= line_in;
         column_ff      <= column_in;
         open_offset_ff <= open_offset_in;
         open_line_ff   <= open_line_in;
         open_column_ff <= open_column_in;
      end
   end

endmodule

>>> sv/bst_emit.sv
// result register: holds one byte's descriptors and sends them one per transaction
module bst_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  bst_pkg::group_type  group,
   output logic                can_load,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_token_kind,
   output logic [15:0]         rsp_start_offset,
   output logic [15:0]         rsp_token_length,
   output logic [15:0]         rsp_start_line,
   output logic [15:0]         rsp_start_column,
   output logic                rsp_last_of_run
);

   function automatic logic [bst_pkg::FIELD_W-1:0] to_field(input bst_pkg::cnt_type v);
      logic [bst_pkg::FIELD_W+bst_pkg::COUNTER_BITS-1:0] wide;
      wide = {{bst_pkg::FIELD_W{1'b0}}, v};
      return wide[bst_pkg::FIELD_W-1:0];
   endfunction

   bst_pkg::group_type grp_ff, grp_in;
   logic               valid_ff, valid_in;
   logic [1:0]         idx_ff, idx_in;
   bst_pkg::rec_type   cur;
   logic               take, is_last;

   assign cur      = grp_ff.recs[idx_ff];
   assign is_last  = (idx_ff == grp_ff.count - 2'd1);
   assign take     = valid_ff && !rsp_stall;
   assign can_load = !valid_ff || (take && is_last);

   always_comb begin
      grp_in   = grp_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         grp_in   = group;
         idx_in   = '0;
         // a byte with no descriptors leaves nothing to send
         valid_in = (group.count != 2'd0);
      end else if (take) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      grp_ff <= grp_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_token_kind   = cur.kind;
   assign rsp_start_offset = to_field(cur.offset);
   assign rsp_token_length = to_field(cur.length);
   assign rsp_start_line   = to_field(cur.line);
   assign rsp_start_column = to_field(cur.column);
   assign rsp_last_of_run  = is_last;

endmodule

>>> sv/byte_stream_tokenizer.sv
// top level of the byte stream tokenizer: input register, scanner and result register
//
// Takes one source byte per req_ transaction and returns token descriptors on
// the rsp_ channel: kind, start offset, length, start line and start column.
// A transaction moves when valid is high and stall is low at a rising edge.
// Set req_end_of_source on the last byte of a source: it closes any open token
// and adds an end token, then all counters restart for the next source.
// Each byte gives zero to three descriptors; rsp_last_of_run marks the final
// one caused by a byte.
// An accepted byte waits in the input register until the result register
// can load; its descriptors are then registered there and offered on rsp_.
// Throughput: one byte per cycle while each byte gives at most one
// descriptor and rsp_stall is low; a byte with more descriptors holds the
// input, as the result register sends at most one descriptor per cycle.
// While rsp_stall is high the offered descriptor holds; req_stall rises while
// the input register is full and the result register cannot load.
// Synchronous reset empties both registers and returns line and column to 1
// and offset to 0; no transaction is offered in the cycle after reset.
module byte_stream_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_token_kind,
   output logic [15:0] rsp_start_offset,
   output logic [15:0] rsp_token_length,
   output logic [15:0] rsp_start_line,
   output logic [15:0] rsp_start_column,
   output logic        rsp_last_of_run
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         byte_ff, byte_in;
   logic               eos_ff, eos_in;
   logic               advance, can_load, accept;
   bst_pkg::group_type group;

   assign advance   = in_valid_ff && can_load;
   assign req_stall = in_valid_ff && !can_load;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in     = byte_ff;
      eos_in      = eos_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         byte_in     = req_in_byte;
         eos_in      = req_end_of_source;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      byte_ff <= byte_in;
      eos_ff  <= eos_in;
   end

   bst_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_byte       (byte_ff),
      .end_of_source (eos_ff),
      .group         (group)
   );

   bst_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .load             (advance),
      .group            (group),
      .can_load         (can_load),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_start_line   (rsp_start_line),
      .rsp_start_column (rsp_start_column),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

>>> sv/bst_checker.sv
// port-level checks on the byte stream tokenizer, bound to the top level
module bst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_token_kind,
   input logic [15:0] rsp_start_offset,
   input logic [15:0] rsp_token_length,
   input logic [15:0] rsp_start_line,
   input logic [15:0] rsp_start_column,
   input logic        rsp_last_of_run
);

   // stalled transaction keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind)
         && $stable(rsp_start_offset) && $stable(rsp_token_length)
         && $stable(rsp_start_line) && $stable(rsp_start_column)
         && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // nothing offered straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // input register is empty straight after reset
   assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled after reset");

   // end token is empty and always the final result of its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == bst_pkg::KIND_END |-> rsp_last_of_run
         && rsp_token_length == 16'd0)
      else $error("malformed end token");

   // single-byte tokens have length one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == bst_pkg::KIND_OPER
         || rsp_token_kind == bst_pkg::KIND_SYMBOL
         || rsp_token_kind == bst_pkg::KIND_ERROR) |-> rsp_token_length == 16'd1)
      else $error("single-byte token with wrong length");

endmodule

bind byte_stream_tokenizer bst_checker u_bst_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_token_kind   (rsp_token_kind),
   .rsp_start_offset (rsp_start_offset),
   .rsp_token_length (rsp_token_length),
   .rsp_start_line   (rsp_start_line),
   .rsp_start_column (rsp_start_column),
   .rsp_last_of_run  (rsp_last_of_run)
);

>>> bench/tokenizer_checker.sv
// descriptor predictor and scoreboard for the byte stream tokenizer
`timescale 1ns / 100ps
module tokenizer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_source,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_token_kind,
   input  logic [15:0] rsp_start_offset,
   input  logic [15:0] rsp_token_length,
   input  logic [15:0] rsp_start_line,
   input  logic [15:0] rsp_start_column,
   input  logic        rsp_last_of_run,
   output int          mismatch_count,
   output int          tokens_due,
   output int          tokens_seen
);

   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_LBRACE     = 8'h7B;
   localparam logic [7:0] CH_RBRACE     = 8'h7D;
   localparam logic [7:0] CH_SEMI       = 8'h3B;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_CR         = 8'h0D;

   typedef struct {
      bst_pkg::kind_type kind;
      bst_pkg::cnt_type  offset;
      bst_pkg::cnt_type  length;
      bst_pkg::cnt_type  line;
      bst_pkg::cnt_type  column;
      logic              last;
   } token_desc_type;

   // scanner state as seen from outside
   bst_pkg::mode_type scan_mode;
   bst_pkg::cnt_type  next_offset;
   bst_pkg::cnt_type  next_line;
   bst_pkg::cnt_type  next_column;
   bst_pkg::cnt_type  tok_offset;
   bst_pkg::cnt_type  tok_line;
   bst_pkg::cnt_type  tok_column;

   token_desc_type run_descs[$];
   token_desc_type tokens_expected[$];

   function automatic bst_pkg::cnt_type sat_up(input bst_pkg::cnt_type v);
      return (v == '1) ? v : bst_pkg::cnt_type'(v + 1'b1);
   endfunction

   function automatic bit is_letter(input logic [7:0] ch);
      return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == CH_UNDERSCORE;
   endfunction

   function automatic bit is_digit(input logic [7:0] ch);
      return ch >= "0" && ch <= "9";
   endfunction

   function automatic void restart_source();
      scan_mode   = bst_pkg::MODE_IDLE;
      next_offset = '0;
      next_line   = bst_pkg::cnt_type'(1);
      next_column = bst_pkg::cnt_type'(1);
      tok_offset  = '0;
      tok_line    = bst_pkg::cnt_type'(1);
      tok_column  = bst_pkg::cnt_type'(1);
   endfunction

   function automatic void open_token(input bst_pkg::mode_type m);
      scan_mode  = m;
      tok_offset = next_offset;
      tok_line   = next_line;
      tok_column = next_column;
   endfunction

   function automatic void add_token(input bst_pkg::kind_type k, input bst_pkg::cnt_type off,
                                     input bst_pkg::cnt_type len,
                                     input bst_pkg::cnt_type line,
                                     input bst_pkg::cnt_type col);
      token_desc_type d;
      d.kind   = k;
      d.offset = off;
      d.length = len;
      d.line   = line;
      d.column = col;
      d.last   = 1'b0;
      run_descs = {run_descs, d};
   endfunction

   // works out every descriptor caused by one source byte
   function automatic void scan_byte(input logic [7:0] ch, input logic eos);
      bit                newline_seen;
      bst_pkg::kind_type k;
      token_desc_type    d;
      int                n;
      newline_seen = 1'b0;
      run_descs.delete();
      if (scan_mode == bst_pkg::MODE_STRING) begin
         if (ch == CH_QUOTE) begin
            add_token(bst_pkg::KIND_STRING, tok_offset,
                      sat_up(bst_pkg::cnt_type'(next_offset - tok_offset)),
                      tok_line, tok_column);
            scan_mode = bst_pkg::MODE_IDLE;
         end
      end else begin
         // a byte that cannot extend the open token closes it and is then scanned afresh
         if (scan_mode == bst_pkg::MODE_IDENT && !(is_letter(ch) || is_digit(ch))) begin
            add_token(bst_pkg::KIND_IDENT, tok_offset,
                      bst_pkg::cnt_type'(next_offset - tok_offset), tok_line, tok_column);
            scan_mode = bst_pkg::MODE_IDLE;
         end else if (scan_mode == bst_pkg::MODE_NUMBER && !is_digit(ch)) begin
            add_token(bst_pkg::KIND_NUMBER, tok_offset,
                      bst_pkg::cnt_type'(next_offset - tok_offset), tok_line, tok_column);
            scan_mode = bst_pkg::MODE_IDLE;
         end
         if (scan_mode == bst_pkg::MODE_IDLE) begin
            if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
               newline_seen = (ch == CH_NEWLINE);
            end else if (is_letter(ch)) begin
               open_token(bst_pkg::MODE_IDENT);
            end else if (is_digit(ch)) begin
               open_token(bst_pkg::MODE_NUMBER);
            end else if (ch == CH_QUOTE) begin
               open_token(bst_pkg::MODE_STRING);
            end else begin
               k = bst_pkg::KIND_ERROR;
               if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH)
                  k = bst_pkg::KIND_OPER;
               else if (ch == CH_LBRACE || ch == CH_RBRACE || ch == CH_SEMI)
                  k = bst_pkg::KIND_SYMBOL;
               add_token(k, next_offset, bst_pkg::cnt_type'(1), next_line, next_column);
            end
         end
      end

      // end of source closes the open token with the flagged byte included
      if (eos && scan_mode != bst_pkg::MODE_IDLE) begin
         case (scan_mode)
            bst_pkg::MODE_IDENT:  k = bst_pkg::KIND_IDENT;
            bst_pkg::MODE_NUMBER: k = bst_pkg::KIND_NUMBER;
            default:              k = bst_pkg::KIND_STRING;
         endcase
         add_token(k, tok_offset, sat_up(bst_pkg::cnt_type'(next_offset - tok_offset)),
                   tok_line, tok_column);
         scan_mode = bst_pkg::MODE_IDLE;
      end

      next_offset = sat_up(next_offset);
      if (newline_seen) begin
         next_line   = sat_up(next_line);
         next_column = bst_pkg::cnt_type'(1);
      end else begin
         next_column = sat_up(next_column);
      end

      if (eos) begin
         add_token(bst_pkg::KIND_END, next_offset, '0, next_line, next_column);
         restart_source();
      end

      n = run_descs.size();
      for (int i = 0; i < n; i++) begin
         d = run_descs[i];
         d.last = (i == n - 1);
         tokens_expected = {tokens_expected, d};
      end
   endfunction

   function automatic void check_field(input string name, input logic [15:0] got,
                                       input logic [15:0] want);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      token_desc_type want;
      if (reset) begin
         restart_source();
         tokens_expected.delete();
      end else begin
         // results are compared before this edge's byte is scanned, so none can match early
         if (rsp_valid && !rsp_stall) begin
            tokens_seen++;
            if (tokens_expected.size() == 0) begin
               $error("descriptor with none expected: kind %0d offset %0d length %0d",
                      rsp_token_kind, rsp_start_offset, rsp_token_length);
               mismatch_count++;
            end else begin
               want = tokens_expected.pop_front();
               check_field("token_kind", 16'(rsp_token_kind), 16'(want.kind));
               check_field("start_offset", rsp_start_offset, want.offset);
               check_field("token_length", rsp_token_length, want.length);
               check_field("start_line", rsp_start_line, want.line);
               check_field("start_column", rsp_start_column, want.column);
               check_field("last_of_run", 16'(rsp_last_of_run), 16'(want.last));
            end
         end
         if (req_valid && !req_stall)
            scan_byte(req_in_byte, req_end_of_source);
      end
      tokens_due <= tokens_expected.size();
   end

endmodule

>>> bench/tb.sv
// testbench top for the byte stream tokenizer: clock, reset, source byte stimulus and verdict
`timescale 1ns / 100ps
module tb;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_BYTES = 390;

   localparam int STALL_NONE     = 0;
   localparam int STALL_LIGHT    = 1;
   localparam int STALL_HEAVY    = 2;
   localparam int STALL_PERIODIC = 3;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte       = '0;
   logic        req_end_of_source = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall         = 1'b0;
   logic [2:0]  rsp_token_kind;
   logic [15:0] rsp_start_offset;
   logic [15:0] rsp_token_length;
   logic [15:0] rsp_start_line;
   logic [15:0] rsp_start_column;
   logic        rsp_last_of_run;

   int mismatch_count;
   int tokens_due;
   int tokens_seen;

   int cycle_count  = 0;
   int bytes_sent   = 0;
   int sources_sent = 0;
   int random_bytes = 0;
   int burst_left   = 0;
   int stall_style  = STALL_NONE;

   logic [7:0] source_q[$];

   always #2 clock = ~clock;

   byte_stream_tokenizer DUT (.*);

   tokenizer_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver stall pattern, changing style every so often
   always @(posedge clock) begin
      if (cycle_count % 150 == 0)
         stall_style <= $urandom_range(STALL_NONE, STALL_PERIODIC);
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
         default:     rsp_stall <= ((cycle_count % 5) < 2);
      endcase
   end

   task automatic send_byte(input logic [7:0] ch, input logic eos);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= ch;
      req_end_of_source <= eos;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0)
         burst_left--;
      bytes_sent++;
      if (eos)
         sources_sent++;
   endtask

   task automatic send_text(input string s, input bit close);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], close && i == s.len() - 1);
   endtask

   // hold off the sender until every outstanding descriptor has arrived
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tokens_due != 0)
         @(posedge clock);
   endtask

   function automatic void queue_byte(input logic [7:0] c);
      source_q = {source_q, c};
   endfunction

   function automatic logic [7:0] pick_ident_char(input bit first);
      int r;
      r = $urandom_range(0, first ? 52 : 62);
      if (r < 26)
         return 8'("a" + r);
      else if (r < 52)
         return 8'("A" + r - 26);
      else if (r == 52)
         return "_";
      return 8'("0" + r - 53);
   endfunction

   function automatic logic [7:0] pick_error_byte();
      string punct;
      int    r;
      punct = "!#$%&'()=,.<>?@[]\\^|~:";
      case ($urandom_range(0, 2))
         0: return 8'($urandom_range(128, 255));
         1: return punct[$urandom_range(0, punct.len() - 1)];
         default: begin
            // control bytes outside the whitespace range, and delete
            r = $urandom_range(0, 27);
            return (r < 9) ? 8'(r) : (r < 27) ? 8'(r + 5) : 8'h7F;
         end
      endcase
   endfunction

   // appends one well-formed token, or a stray byte, to the source being built
   task automatic add_random_token();
      int         pick;
      int         r;
      logic [7:0] c;
      pick = $urandom_range(0, 19);
      if (pick <= 4) begin
         queue_byte(pick_ident_char(1'b1));
         repeat ($urandom_range(0, 6)) queue_byte(pick_ident_char(1'b0));
      end else if (pick <= 7) begin
         repeat ($urandom_range(1, 5)) queue_byte(8'("0" + $urandom_range(0, 9)));
      end else if (pick <= 9) begin
         queue_byte("\"");
         repeat ($urandom_range(0, 6)) begin
            c = ($urandom_range(0, 5) == 0) ? 8'h0A : 8'($urandom_range(0, 255));
            if (c == "\"")
               c = "q";
            queue_byte(c);
         end
         // some strings stay open until the end of the source
         if ($urandom_range(0, 9) != 0)
            queue_byte("\"");
      end else if (pick <= 11) begin
         case ($urandom_range(0, 3))
            0:       queue_byte("+");
            1:       queue_byte("-");
            2:       queue_byte("*");
            default: queue_byte("/");
         endcase
      end else if (pick == 12) begin
         case ($urandom_range(0, 2))
            0:       queue_byte("{");
            1:       queue_byte("}");
            default: queue_byte(";");
         endcase
      end else if (pick <= 15) begin
         repeat ($urandom_range(1, 3)) begin
            r = $urandom_range(0, 5);
            queue_byte((r == 0) ? 8'h20 : 8'(8 + r));
         end
      end else if (pick <= 17) begin
         queue_byte(pick_error_byte());
      end else begin
         queue_byte(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // one-byte source, then a closing byte that also ends the source
      send_text("x", 1'b1);
      send_text("ab+", 1'b1);
      // number cut by a letter, whitespace kinds, newline inside a string, every
      // symbol and the other operators, error bytes, and a string left open at the end
      send_text("12az \t\n\"q\n\"{};*/-@", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_text("\v\f\015\"7", 1'b1);
      wait_drained();

      while (random_bytes < RANDOM_BYTES) begin
         source_q.delete();
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 8)) queue_byte(8'($urandom_range(0, 255)));
         else
            repeat ($urandom_range(1, 14)) add_random_token();
         if ($urandom_range(0, 7) == 0)
            wait_drained();
         foreach (source_q[i])
            send_byte(source_q[i], i == source_q.size() - 1);
         random_bytes += source_q.size();
      end

      wait_drained();
      repeat (20) @(posedge clock);

      $display("run: %0d source bytes in %0d sources, %0d token descriptors checked",
               bytes_sent, sources_sent, tokens_seen);
      $display("run: every token kind, open strings at end of source, bursty input and stalls");
      if (mismatch_count == 0 && tokens_due == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
sv/bst_pkg.sv
sv/bst_scan.sv
sv/bst_emit.sv
sv/byte_stream_tokenizer.sv
sv/bst_checker.sv
bench/tokenizer_checker.sv
bench/tb.sv
